// ===== hw/rtl/srvramp_pkg.sv =====
// Shared types and constants for the servo position ramp.
package srvramp_pkg;

	localparam int unsigned POS_W = 8;
	localparam int unsigned TICK_W = 9;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [POS_W-1:0] TRIM_STEP = 8'd3;
	localparam logic [POS_W-1:0] TRIM_UP_LIMIT = 8'd174;
	localparam logic [POS_W-1:0] TRIM_DOWN_LIMIT = 8'd5;
	localparam logic [TICK_W-1:0] TICK_SAT = 9'd256;

	localparam logic [POS_W-1:0] RST_STEP_INTERVAL = 8'd20;
	localparam logic [POS_W-1:0] RST_DEFAULT_MIN = 8'd80;
	localparam logic [POS_W-1:0] RST_DEFAULT_MAX = 8'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP_INTERVAL = 2'd0,
		REG_DEFAULT_MIN   = 2'd1,
		REG_DEFAULT_MAX   = 2'd2
	} reg_idx_e;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_SET_TARGET = 3'd1,
		CMD_TRIM_UP    = 3'd2,
		CMD_TRIM_DOWN  = 3'd3,
		CMD_SET_MIN    = 3'd4,
		CMD_SET_MAX    = 3'd5,
		CMD_RELOAD     = 3'd6
	} cmd_e;

	typedef struct packed {
		logic [POS_W-1:0] step_interval;
		logic [POS_W-1:0] default_min;
		logic [POS_W-1:0] default_max;
	} cfg_t;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [POS_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             moved;
		logic             drive_on;
		logic             relay_a;
		logic             relay_b;
		logic             target_now;
		logic [POS_W-1:0] min_now;
		logic [POS_W-1:0] max_now;
	} result_t;

endpackage

// ===== hw/rtl/srvramp_cfg.sv =====
// Configuration registers: step interval and default end positions.
module srvramp_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [srvramp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srvramp_pkg::POS_W-1:0]       cfg_data,
	output srvramp_pkg::cfg_t                   cfg
);
	import srvramp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_interval <= RST_STEP_INTERVAL;
			cfg_q.default_min <= RST_DEFAULT_MIN;
			cfg_q.default_max <= RST_DEFAULT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_INTERVAL: cfg_q.step_interval <= cfg_data;
				REG_DEFAULT_MIN:   cfg_q.default_min <= cfg_data;
				REG_DEFAULT_MAX:   cfg_q.default_max <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/srvramp_in_stage.sv =====
// Input register for requests, with stall back to the sender.
module srvramp_in_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [2:0]                     cmd,
	input  logic [srvramp_pkg::POS_W-1:0]  value,
	input  logic                           advance,
	output logic                           valid_s1,
	output srvramp_pkg::item_t             item_s1
);
	import srvramp_pkg::*;

	logic load;

	// stage frees up when empty or when its request moves on this cycle
	assign req_stall = valid_s1 && !advance;
	assign load = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cmd <= cmd;
			item_s1.value <= value;
		end
	end

endmodule

// ===== hw/rtl/srvramp_core.sv =====
// Servo state and per-request update: ticks, stepping, trim, end positions.
module srvramp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  srvramp_pkg::item_t   item,
	input  srvramp_pkg::cfg_t    cfg,
	output srvramp_pkg::result_t result
);
	import srvramp_pkg::*;

	logic [POS_W-1:0]  position_q, min_end_q, max_end_q;
	logic              target_q, drive_q, relay_a_q, relay_b_q;
	logic [TICK_W-1:0] tick_q;

	logic [POS_W-1:0]  position_n, min_end_n, max_end_n, goal, active_end;
	logic              target_n, drive_n, relay_a_n, relay_b_n, moved;
	logic [TICK_W-1:0] tick_n, tick_inc;

	assign goal = target_q ? max_end_q : min_end_q;
	assign active_end = goal;
	assign tick_inc = (tick_q == TICK_SAT) ? tick_q : tick_q + 1'b1;

	always_comb begin
		position_n = position_q;
		min_end_n = min_end_q;
		max_end_n = max_end_q;
		target_n = target_q;
		drive_n = drive_q;
		relay_a_n = relay_a_q;
		relay_b_n = relay_b_q;
		tick_n = tick_q;
		moved = 1'b0;
		unique case (cmd_e'(item.cmd))
			CMD_TICK: begin
				tick_n = tick_inc;
				if (tick_inc > {1'b0, cfg.step_interval}) begin
					tick_n = '0;
					if (position_q < goal) begin
						position_n = position_q + 1'b1;
					end else if (position_q > goal) begin
						position_n = position_q - 1'b1;
					end
					if (position_n != position_q) begin
						moved = 1'b1;
						relay_a_n = 1'b0;
						relay_b_n = 1'b0;
						if (position_n != goal) begin
							drive_n = 1'b1;
						end else begin
							drive_n = 1'b0;
							relay_a_n = !target_q;
							relay_b_n = target_q;
						end
					end
				end
			end
			CMD_SET_TARGET: target_n = (item.value != '0);
			CMD_TRIM_UP: begin
				if (active_end <= TRIM_UP_LIMIT) begin
					if (target_q) max_end_n = max_end_q + TRIM_STEP;
					else min_end_n = min_end_q + TRIM_STEP;
				end
			end
			CMD_TRIM_DOWN: begin
				if (active_end >= TRIM_DOWN_LIMIT) begin
					if (target_q) max_end_n = max_end_q - TRIM_STEP;
					else min_end_n = min_end_q - TRIM_STEP;
				end
			end
			CMD_SET_MIN: min_end_n = item.value;
			CMD_SET_MAX: max_end_n = item.value;
			CMD_RELOAD: begin
				min_end_n = cfg.default_min;
				max_end_n = cfg.default_max;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= RST_DEFAULT_MIN;
			min_end_q <= RST_DEFAULT_MIN;
			max_end_q <= RST_DEFAULT_MAX;
			target_q <= 1'b0;
			tick_q <= '0;
			drive_q <= 1'b0;
			relay_a_q <= 1'b1;
			relay_b_q <= 1'b0;
		end else if (fire) begin
			position_q <= position_n;
			min_end_q <= min_end_n;
			max_end_q <= max_end_n;
			target_q <= target_n;
			tick_q <= tick_n;
			drive_q <= drive_n;
			relay_a_q <= relay_a_n;
			relay_b_q <= relay_b_n;
		end
	end

	always_comb begin
		result.position = position_n;
		result.moved = moved;
		result.drive_on = drive_n;
		result.relay_a = relay_a_n;
		result.relay_b = relay_b_n;
		result.target_now = target_n;
		result.min_now = min_end_n;
		result.max_now = max_end_n;
	end

	a_relays_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(relay_a_q && relay_b_q))
		else $error("both relays raised");

	a_drive_drops_relays: assert property (@(posedge clk) disable iff (!arst_n)
		drive_q |-> (!relay_a_q && !relay_b_q))
		else $error("relay raised while drive is on");

	a_tick_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q <= TICK_SAT)
		else $error("tick counter past saturation");

	a_step_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && moved) |=> (position_q == $past(position_q) + 8'd1
			|| position_q == $past(position_q) - 8'd1))
		else $error("position moved by more than one unit");

	a_quiet_holds_position: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !moved) |=> $stable(position_q))
		else $error("position changed without a step");

endmodule

// ===== hw/rtl/srvramp_out_reg.sv =====
// Result register feeding the response channel.
module srvramp_out_reg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  srvramp_pkg::result_t result_in,
	input  logic                 res_stall,
	output logic                 res_valid,
	output logic                 advance,
	output srvramp_pkg::result_t result_s2
);
	import srvramp_pkg::*;

	// slot is free when empty or being taken this cycle
	assign advance = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && advance) begin
			result_s2 <= result_in;
		end
	end

endmodule

// ===== hw/rtl/servo_position_ramp.sv =====
// Top level of the two-position servo ramp with trim.
//
// Requests (cmd, value) arrive on a valid/stall channel; each one yields
// exactly one response on a second valid/stall channel carrying the
// position, the moved flag, drive and relay outputs, the target side and
// both end positions as they stand after that request.
// An accepted request passes through one input register, then the state
// update and the result register, whose loading raises response valid.
// Throughput is one request per cycle while the response side does not
// stall; the whole update is a few compares and an 8-bit add between those two registers.
// While the response side stalls, the response register holds and the
// input register keeps one more request; further requests are stalled.
// The configuration port (step interval, default min, default max) writes
// at once and is meant to be used while no request is in flight; the new
// defaults reach the ends only on a reload request.
// Reset clears both channels, loads the register defaults (20, 80, 100),
// puts the position and 0-end at 80, the 1-end at 100, target 0, relay a
// raised and the drive off.
module servo_position_ramp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  logic [2:0]                         cmd,
	input  logic [srvramp_pkg::POS_W-1:0]      value,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic [srvramp_pkg::POS_W-1:0]      position,
	output logic                               moved,
	output logic                               drive_on,
	output logic                               relay_a,
	output logic                               relay_b,
	output logic                               target_now,
	output logic [srvramp_pkg::POS_W-1:0]      min_now,
	output logic [srvramp_pkg::POS_W-1:0]      max_now,
	input  logic                               cfg_we,
	input  logic [srvramp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [srvramp_pkg::POS_W-1:0]      cfg_data
);
	import srvramp_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	result_t result_c, result_s2;
	logic    valid_s1, advance, fire;

	assign fire = valid_s1 && advance;

	srvramp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	srvramp_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.value     (value),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	srvramp_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_c)
	);

	srvramp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.result_in (result_c),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.advance   (advance),
		.result_s2 (result_s2)
	);

	assign position = result_s2.position;
	assign moved = result_s2.moved;
	assign drive_on = result_s2.drive_on;
	assign relay_a = result_s2.relay_a;
	assign relay_b = result_s2.relay_b;
	assign target_now = result_s2.target_now;
	assign min_now = result_s2.min_now;
	assign max_now = result_s2.max_now;

endmodule
